/* src/bgd_pkg.sv */
// ----------------------------------------------------------------------------
// bgd_pkg: grade 2 braille word decoder shared definitions
// Expansion tables, word descriptor layout and lookup helpers.
// ----------------------------------------------------------------------------
package bgd_pkg;

   localparam int BGD_QUEUE_DEPTH = 4;
   localparam int MAX_CHARS       = 9;

   localparam logic [5:0] SIGN_CAPITAL = 6'h20;
   localparam logic [5:0] SIGN_NUMBER  = 6'h3C;

   // expansion kinds
   localparam logic [2:0] KIND_WORD   = 3'd0;
   localparam logic [2:0] KIND_STRONG = 3'd1;
   localparam logic [2:0] KIND_LOWER  = 3'd2;
   localparam logic [2:0] KIND_LETTER = 3'd3;
   localparam logic [2:0] KIND_DIGIT  = 3'd4;
   localparam logic [2:0] KIND_PUNCT  = 3'd5;

   localparam logic [5:0] ALPHA_PAT [26] = '{
      6'h01, 6'h03, 6'h09, 6'h19, 6'h11, 6'h0B, 6'h1B, 6'h13, 6'h0A, 6'h1A,
      6'h05, 6'h07, 6'h0D, 6'h1D, 6'h15, 6'h0F, 6'h1F, 6'h17, 6'h0E, 6'h1E,
      6'h25, 6'h27, 6'h3A, 6'h2D, 6'h3D, 6'h35
   };

   // text is right-justified: char k of a len-char string sits at 8*(len-1-k)
   typedef struct packed {
      logic        hit;
      logic [3:0]  len;
      logic [71:0] text;
   } text_type;

   typedef struct packed {
      logic       hit;
      logic [4:0] idx;
   } alpha_type;

   // one queued word to expand
   typedef struct packed {
      logic [2:0] kind;
      logic [5:0] pat;
      logic       upper;
      logic [3:0] len;
   } desc_type;

   function automatic text_type mk(input logic [71:0] s, input logic [3:0] n);
      text_type r;
      r.hit  = 1'b1;
      r.len  = n;
      r.text = s;
      return r;
   endfunction

   function automatic text_type word_lookup(input logic [5:0] p);
      text_type r;
      r = '0;
      unique case (p)
         6'h03: r = mk("but", 4'd3);
         6'h09: r = mk("can", 4'd3);
         6'h19: r = mk("do", 4'd2);
         6'h11: r = mk("every", 4'd5);
         6'h0B: r = mk("from", 4'd4);
         6'h1B: r = mk("go", 4'd2);
         6'h13: r = mk("have", 4'd4);
         6'h1A: r = mk("just", 4'd4);
         6'h05: r = mk("knowledge", 4'd9);
         6'h07: r = mk("like", 4'd4);
         6'h0D: r = mk("more", 4'd4);
         6'h1D: r = mk("not", 4'd3);
         6'h0F: r = mk("people", 4'd6);
         6'h1F: r = mk("quite", 4'd5);
         6'h17: r = mk("rather", 4'd6);
         6'h0E: r = mk("so", 4'd2);
         6'h1E: r = mk("that", 4'd4);
         6'h25: r = mk("us", 4'd2);
         6'h27: r = mk("very", 4'd4);
         6'h3A: r = mk("will", 4'd4);
         6'h2D: r = mk("it", 4'd2);
         6'h3D: r = mk("you", 4'd3);
         6'h35: r = mk("as", 4'd2);
         6'h21: r = mk("child", 4'd5);
         6'h29: r = mk("shall", 4'd5);
         6'h39: r = mk("this", 4'd4);
         6'h31: r = mk("which", 4'd5);
         6'h33: r = mk("out", 4'd3);
         6'h0C: r = mk("still", 4'd5);
         6'h2E: r = mk("the", 4'd3);
         6'h2F: r = mk("and", 4'd3);
         6'h3F: r = mk("for", 4'd3);
         6'h37: r = mk("of", 4'd2);
         6'h3E: r = mk("with", 4'd4);
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic text_type strong_lookup(input logic [5:0] p);
      text_type r;
      r = '0;
      unique case (p)
         6'h21: r = mk("ch", 4'd2);
         6'h23: r = mk("gh", 4'd2);
         6'h29: r = mk("sh", 4'd2);
         6'h39: r = mk("th", 4'd2);
         6'h31: r = mk("wh", 4'd2);
         6'h2B: r = mk("ed", 4'd2);
         6'h3B: r = mk("er", 4'd2);
         6'h33: r = mk("ou", 4'd2);
         6'h2A: r = mk("ow", 4'd2);
         6'h0C: r = mk("st", 4'd2);
         6'h2C: r = mk("ing", 4'd3);
         6'h1C: r = mk("ar", 4'd2);
         6'h2E: r = mk("the", 4'd3);
         6'h2F: r = mk("and", 4'd3);
         6'h3F: r = mk("for", 4'd3);
         6'h37: r = mk("of", 4'd2);
         6'h3E: r = mk("with", 4'd4);
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic text_type lower_lookup(input logic [5:0] p);
      text_type r;
      r = '0;
      unique case (p)
         6'h06: r = mk("bb", 4'd2);
         6'h12: r = mk("cc", 4'd2);
         6'h36: r = mk("gg", 4'd2);
         6'h22: r = mk("en", 4'd2);
         6'h14: r = mk("in", 4'd2);
         6'h02: r = mk("ea", 4'd2);
         6'h16: r = mk("ff", 4'd2);
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic text_type punct_lookup(input logic [5:0] p);
      text_type r;
      r = '0;
      unique case (p)
         6'h02: r = mk(",", 4'd1);
         6'h06: r = mk(";", 4'd1);
         6'h12: r = mk(":", 4'd1);
         6'h16: r = mk("!", 4'd1);
         6'h34: r = mk(".", 4'd1);
         6'h26: r = mk("?", 4'd1);
         6'h0C: r = mk("/", 4'd1);
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic alpha_type alpha_lookup(input logic [5:0] p);
      alpha_type r;
      r = '0;
      for (int i = 0; i < 26; i++) begin
         if (ALPHA_PAT[i] == p) begin
            r.hit = 1'b1;
            r.idx = 5'(i);
         end
      end
      return r;
   endfunction

   // full text of a queued word, used by the back end
   function automatic text_type expansion_text(input logic [2:0] kind,
                                               input logic [5:0] pat);
      text_type  r;
      alpha_type a;
      r = '0;
      a = alpha_lookup(pat);
      unique case (kind)
         KIND_WORD:   r = word_lookup(pat);
         KIND_STRONG: r = strong_lookup(pat);
         KIND_LOWER:  r = lower_lookup(pat);
         KIND_PUNCT:  r = punct_lookup(pat);
         KIND_LETTER: begin
            r.hit       = 1'b1;
            r.len       = 4'd1;
            r.text[6:0] = 7'h61 + 7'(a.idx);
         end
         KIND_DIGIT: begin
            r.hit       = 1'b1;
            r.len       = 4'd1;
            r.text[6:0] = (a.idx == 5'd9) ? 7'h30 : 7'h31 + 7'(a.idx);
         end
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

/* src/bgd_front.sv */
// ----------------------------------------------------------------------------
// bgd_front: cell classifier
// Accepts cells, tracks the capital and number flags, queues a descriptor.
// ----------------------------------------------------------------------------
module bgd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [5:0]       req_cell_req,
   input  logic             req_first_of_word,
   input  logic             req_last_of_word,
   input  logic             q_full,
   output logic             q_push,
   output bgd_pkg::desc_type q_data
);
   import bgd_pkg::*;

   logic      cap_ff, cap_in;
   logic      num_ff, num_in;
   logic      accept;
   logic      emit;
   logic      cap_v, num_v;
   text_type  word_t, strong_t, lower_t, punct_t;
   alpha_type alpha_t;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign q_push    = accept && emit;

   assign word_t   = word_lookup(req_cell_req);
   assign strong_t = strong_lookup(req_cell_req);
   assign lower_t  = lower_lookup(req_cell_req);
   assign punct_t  = punct_lookup(req_cell_req);
   assign alpha_t  = alpha_lookup(req_cell_req);

   always_comb begin
      cap_v  = req_first_of_word ? 1'b0 : cap_ff;
      num_v  = req_first_of_word ? 1'b0 : num_ff;
      emit   = 1'b0;
      q_data = '0;
      q_data.pat = req_cell_req;
      if (req_first_of_word && req_last_of_word && word_t.hit) begin
         emit        = 1'b1;
         q_data.kind = KIND_WORD;
         q_data.len  = word_t.len;
      end else if (req_cell_req == SIGN_CAPITAL) begin
         cap_v = 1'b1;
      end else if (req_cell_req == SIGN_NUMBER) begin
         num_v = 1'b1;
      end else if (num_v && alpha_t.hit && alpha_t.idx <= 5'd9) begin
         emit        = 1'b1;
         q_data.kind = KIND_DIGIT;
         q_data.len  = 4'd1;
      end else begin
         num_v = 1'b0;
         if (strong_t.hit) begin
            emit        = 1'b1;
            q_data.kind = KIND_STRONG;
            q_data.len  = strong_t.len;
         end else if (!req_first_of_word && lower_t.hit) begin
            emit        = 1'b1;
            q_data.kind = KIND_LOWER;
            q_data.len  = lower_t.len;
         end else if (alpha_t.hit) begin
            emit        = 1'b1;
            q_data.kind = KIND_LETTER;
            q_data.len  = 4'd1;
         end else if (punct_t.hit) begin
            emit        = 1'b1;
            q_data.kind = KIND_PUNCT;
            q_data.len  = 4'd1;
         end
         // capital applies to groupsigns and letters, then drops
         if (emit && q_data.kind != KIND_PUNCT) begin
            q_data.upper = cap_v;
            cap_v        = 1'b0;
         end
      end
   end

   assign cap_in = accept ? cap_v : cap_ff;
   assign num_in = accept ? num_v : num_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= 1'b0;
         num_ff <= 1'b0;
      end else begin
         cap_ff <= cap_in;
         num_ff <= num_in;
      end
   end

endmodule

/* src/bgd_queue.sv */
// ----------------------------------------------------------------------------
// bgd_queue: descriptor queue
// Small FIFO between the classifier and the character emitter.
// ----------------------------------------------------------------------------
module bgd_queue #(
   parameter int DEPTH = bgd_pkg::BGD_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bgd_pkg::desc_type push_data,
   input  logic              pop,
   output bgd_pkg::desc_type head,
   output logic              full,
   output logic              not_empty
);
   import bgd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   desc_type           entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* src/bgd_back.sv */
// ----------------------------------------------------------------------------
// bgd_back: character emitter
// Pops descriptors and streams their characters through an output register.
// ----------------------------------------------------------------------------
module bgd_back (
   input  logic              clock,
   input  logic              reset,
   input  bgd_pkg::desc_type q_head,
   input  logic              q_not_empty,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [6:0]        rsp_text_char,
   output logic              rsp_last_of_cell
);
   import bgd_pkg::*;

   desc_type   cur_ff, cur_in;
   logic       cur_valid_ff, cur_valid_in;
   logic [3:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [6:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       out_free;
   logic       is_last;
   logic [3:0] pos;
   logic [6:0] cur_char;
   text_type   cur_text;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign cur_text = expansion_text(cur_ff.kind, cur_ff.pat);
   assign is_last  = (idx_ff == cur_ff.len - 4'd1);
   assign pos      = cur_ff.len - 4'd1 - idx_ff;

   always_comb begin
      cur_char = '0;
      for (int i = 0; i < MAX_CHARS; i++) begin
         if (pos == 4'(i)) begin
            cur_char = cur_text.text[8*i +: 7];
         end
      end
      // uppercase the first character of a capitalized word
      if (cur_ff.upper && idx_ff == 4'd0 && cur_char >= 7'h61 && cur_char <= 7'h7A) begin
         cur_char = cur_char - 7'h20;
      end
   end

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      q_pop        = 1'b0;
      if (out_free) begin
         rsp_valid_in = cur_valid_ff;
         if (cur_valid_ff) begin
            char_in = cur_char;
            last_in = is_last;
            if (is_last) begin
               q_pop        = q_not_empty;
               cur_valid_in = q_not_empty;
               cur_in       = q_head;
               idx_in       = 4'd0;
            end else begin
               idx_in = idx_ff + 4'd1;
            end
         end
      end
      if (!cur_valid_ff && q_not_empty) begin
         q_pop        = 1'b1;
         cur_valid_in = 1'b1;
         cur_in       = q_head;
         idx_in       = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= 4'd0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_text_char    = char_ff;
   assign rsp_last_of_cell = last_ff;

endmodule

/* src/braille_grade2_word_decoder_core.sv */
// Latency: an accepted cell is written into the queue, then loaded as the emitter's
//   current descriptor; its first character then enters the output register.
// Throughput: one cell per cycle into the queue while it has room; the emitter
//   sends one character per cycle unless stalled; a cell's text is 1 to 9 chars.
// Reset: synchronous, active high; clears both flags, the queue and the output.
// ----------------------------------------------------------------------------
// braille_grade2_word_decoder_core: grade 2 braille back-translation
// Turns six-dot cells into ASCII text, one character per output word.
// ----------------------------------------------------------------------------
module braille_grade2_word_decoder_core #(
   parameter int QUEUE_DEPTH = bgd_pkg::BGD_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   // cell input
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [5:0] req_cell_req,
   input  logic       req_first_of_word,
   input  logic       req_last_of_word,
   // character output
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [6:0] rsp_text_char,
   output logic       rsp_last_of_cell
);
   import bgd_pkg::*;

   // Front end: classify each cell against the flags and turn it into a
   // descriptor (kind, pattern, capitalize, length). Cells that give no text
   // (capital sign, number sign, unknown) only update the flags.
   desc_type push_data;
   logic     push;

   // Queue: lets the classifier keep taking cells while long expansions drain.
   desc_type head;
   logic     full;
   logic     not_empty;
   logic     pop;

   bgd_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cell_req      (req_cell_req),
      .req_first_of_word (req_first_of_word),
      .req_last_of_word  (req_last_of_word),
      .q_full            (full),
      .q_push            (push),
      .q_data            (push_data)
   );

   bgd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .full      (full),
      .not_empty (not_empty)
   );

   // Back end: hold the current descriptor, advance a character index and
   // drop each character into the output register when it is free. The next
   // descriptor is popped in the same cycle the last character goes out.
   bgd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_head           (head),
      .q_not_empty      (not_empty),
      .q_pop            (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_text_char    (rsp_text_char),
      .rsp_last_of_cell (rsp_last_of_cell)
   );

endmodule

/* src/bgd_checker.sv */
// ----------------------------------------------------------------------------
// bgd_checker: port-level checks for the braille decoder
// Watches the output word stream of the top level.
// ----------------------------------------------------------------------------
module bgd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [6:0] rsp_text_char,
   input logic       rsp_last_of_cell
);

   // hold a stalled output word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_text_char)
         && $stable(rsp_last_of_cell))
      else $error("stalled output word changed");

   // the characters of one cell stream without a gap
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_of_cell |=> rsp_valid)
      else $error("gap inside a cell expansion");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output word right after reset");

   // no output in the first cycle after reset even if a cell was taken
   a_reset_latency: assert property (@(posedge clock)
      $past(reset) && !reset |=> !rsp_valid)
      else $error("output word too early after reset");

   // the queue is empty after reset, so the input is ready
   a_reset_ready: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("input stalled right after reset");

endmodule

bind braille_grade2_word_decoder_core bgd_checker u_bgd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_text_char    (rsp_text_char),
   .rsp_last_of_cell (rsp_last_of_cell)
);

/* tb/sv/bgd_text_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgd_text_checker: expected-text scoreboard for the braille word decoder
// Watches both channels, expands every accepted cell into the characters it
// must produce and compares each accepted output word against them in order.
// ----------------------------------------------------------------------------
module bgd_text_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [5:0] req_cell_req,
   input  logic       req_first_of_word,
   input  logic       req_last_of_word,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [6:0] rsp_text_char,
   input  logic       rsp_last_of_cell,
   output int         mismatch_count,
   output int         outstanding
);

   typedef struct packed {
      logic [6:0] ch;
      logic       last;
   } char_slot_type;

   localparam bit [5:0] LETTER_DOTS [26] = '{
      6'h01, 6'h03, 6'h09, 6'h19, 6'h11, 6'h0B, 6'h1B, 6'h13, 6'h0A, 6'h1A,
      6'h05, 6'h07, 6'h0D, 6'h1D, 6'h15, 6'h0F, 6'h1F, 6'h17, 6'h0E, 6'h1E,
      6'h25, 6'h27, 6'h3A, 6'h2D, 6'h3D, 6'h35
   };

   char_slot_type expected_chars [$];
   bit            cap_armed;
   bit            digits_on;
   int            errs;

   assign mismatch_count = errs;

   function automatic string whole_word_text(input bit [5:0] dots);
      case (dots)
         6'h03: return "but";
         6'h09: return "can";
         6'h19: return "do";
         6'h11: return "every";
         6'h0B: return "from";
         6'h1B: return "go";
         6'h13: return "have";
         6'h1A: return "just";
         6'h05: return "knowledge";
         6'h07: return "like";
         6'h0D: return "more";
         6'h1D: return "not";
         6'h0F: return "people";
         6'h1F: return "quite";
         6'h17: return "rather";
         6'h0E: return "so";
         6'h1E: return "that";
         6'h25: return "us";
         6'h27: return "very";
         6'h3A: return "will";
         6'h2D: return "it";
         6'h3D: return "you";
         6'h35: return "as";
         6'h21: return "child";
         6'h29: return "shall";
         6'h39: return "this";
         6'h31: return "which";
         6'h33: return "out";
         6'h0C: return "still";
         6'h2E: return "the";
         6'h2F: return "and";
         6'h3F: return "for";
         6'h37: return "of";
         6'h3E: return "with";
         default: return "";
      endcase
   endfunction

   function automatic string contraction_text(input bit [5:0] dots);
      case (dots)
         6'h21: return "ch";
         6'h23: return "gh";
         6'h29: return "sh";
         6'h39: return "th";
         6'h31: return "wh";
         6'h2B: return "ed";
         6'h3B: return "er";
         6'h33: return "ou";
         6'h2A: return "ow";
         6'h0C: return "st";
         6'h2C: return "ing";
         6'h1C: return "ar";
         6'h2E: return "the";
         6'h2F: return "and";
         6'h3F: return "for";
         6'h37: return "of";
         6'h3E: return "with";
         default: return "";
      endcase
   endfunction

   function automatic string inner_contraction_text(input bit [5:0] dots);
      case (dots)
         6'h06: return "bb";
         6'h12: return "cc";
         6'h36: return "gg";
         6'h22: return "en";
         6'h14: return "in";
         6'h02: return "ea";
         6'h16: return "ff";
         default: return "";
      endcase
   endfunction

   function automatic string punctuation_text(input bit [5:0] dots);
      case (dots)
         6'h02: return ",";
         6'h06: return ";";
         6'h12: return ":";
         6'h16: return "!";
         6'h34: return ".";
         6'h26: return "?";
         6'h0C: return "/";
         default: return "";
      endcase
   endfunction

   function automatic int letter_index(input bit [5:0] dots);
      int idx;
      idx = -1;
      for (int i = 0; i < 26; i++) begin
         if (LETTER_DOTS[i] == dots) idx = i;
      end
      return idx;
   endfunction

   // queue one character per output word, the final one tagged as end of cell
   task automatic queue_text(input string s, input bit up);
      char_slot_type slot;
      byte           b;
      bit [6:0]      c;
      int            k;
      for (k = 0; k < s.len(); k++) begin
         b = s.getc(k);
         c = b[6:0];
         if (k == 0 && up && c >= 7'h61 && c <= 7'h7A) c = c - 7'd32;
         slot.ch   = c;
         slot.last = (k == s.len() - 1);
         expected_chars.push_back(slot);
      end
   endtask

   task automatic predict_cell(input bit [5:0] dots, input bit first, input bit last);
      string s;
      int    li;
      bit    done;
      bit    up;
      done = 1'b0;
      s    = "";
      if (first) begin
         cap_armed = 1'b0;
         digits_on = 1'b0;
         if (last) begin
            s = whole_word_text(dots);
            if (s != "") begin
               queue_text(s, 1'b0);
               done = 1'b1;
            end
         end
      end
      li = letter_index(dots);
      if (!done) begin
         if (dots == bgd_pkg::SIGN_CAPITAL) begin
            cap_armed = 1'b1;
            done      = 1'b1;
         end else if (dots == bgd_pkg::SIGN_NUMBER) begin
            digits_on = 1'b1;
            done      = 1'b1;
         end
      end
      if (!done && digits_on) begin
         if (li >= 0 && li <= 9) begin
            s = "0";
            if (li != 9) s.putc(0, byte'(8'h31 + li));
            queue_text(s, 1'b0);
            done = 1'b1;
         end else begin
            digits_on = 1'b0;
         end
      end
      if (!done) begin
         s = contraction_text(dots);
         if (s == "" && !first) s = inner_contraction_text(dots);
         if (s == "" && li >= 0) begin
            s = "a";
            s.putc(0, byte'(8'h61 + li));
         end
         if (s != "") begin
            up        = cap_armed;
            cap_armed = 1'b0;
            queue_text(s, up);
         end else begin
            queue_text(punctuation_text(dots), 1'b0);
         end
      end
   endtask

   always @(posedge clock) begin
      char_slot_type want;
      if (reset) begin
         expected_chars.delete();
         cap_armed = 1'b0;
         digits_on = 1'b0;
      end else begin
         if (req_valid && !req_stall)
            predict_cell(req_cell_req, req_first_of_word, req_last_of_word);
         if (rsp_valid && !rsp_stall) begin
            if (expected_chars.size() == 0) begin
               errs++;
               $display("%0t: unexpected char, expected none, actual %h last %b",
                        $time, rsp_text_char, rsp_last_of_cell);
            end else begin
               want = expected_chars.pop_front();
               if (rsp_text_char !== want.ch) begin
                  errs++;
                  $display("%0t: text_char expected %h actual %h",
                           $time, want.ch, rsp_text_char);
               end
               if (rsp_last_of_cell !== want.last) begin
                  errs++;
                  $display("%0t: last_of_cell expected %b actual %b",
                           $time, want.last, rsp_last_of_cell);
               end
            end
         end
      end
      outstanding <= expected_chars.size();
   end

endmodule

/* tb/sv/braille_grade2_word_decoder_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// braille_grade2_word_decoder_core_tb: stimulus and verdict for the decoder
// Feeds directed cells, a back-pressure phase and random words, lets the
// checker score every output word, and reports the outcome once drained.
// ----------------------------------------------------------------------------
module braille_grade2_word_decoder_core_tb;

   localparam int WATCHDOG_LIMIT   = 1000;
   localparam int RANDOM_ITEMS     = 240;
   localparam int PRESSURE_ITEMS   = 24;
   localparam int CALM_ITEMS       = 40;
   localparam int LONG_HOLD_CYCLES = 80;

   // dot patterns of a..j, which read as 1..9,0 after a number sign
   localparam bit [5:0] DIGIT_DOTS [10] = '{
      6'h01, 6'h03, 6'h09, 6'h19, 6'h11, 6'h0B, 6'h1B, 6'h13, 6'h0A, 6'h1A
   };

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [5:0] req_cell_req;
   logic       req_first_of_word;
   logic       req_last_of_word;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [6:0] rsp_text_char;
   logic       rsp_last_of_cell;

   int mismatch_count;
   int outstanding;
   int items_sent;
   int quiet_cycles;
   bit req_idle_on;
   bit rsp_idle_on;
   bit long_hold_due;
   bit long_hold_taken;

   braille_grade2_word_decoder_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cell_req      (req_cell_req),
      .req_first_of_word (req_first_of_word),
      .req_last_of_word  (req_last_of_word),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_text_char     (rsp_text_char),
      .rsp_last_of_cell  (rsp_last_of_cell)
   );

   bgd_text_checker text_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cell_req      (req_cell_req),
      .req_first_of_word (req_first_of_word),
      .req_last_of_word  (req_last_of_word),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_text_char     (rsp_text_char),
      .rsp_last_of_cell  (rsp_last_of_cell),
      .mismatch_count    (mismatch_count),
      .outstanding       (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Offer one cell and hold it until the decoder takes it. An optional idle
   // burst goes first; when none is drawn, valid stays high from the previous
   // cell so it is never dropped and raised in the same step.
   task automatic send_cell(input bit [5:0] dots, input bit first, input bit last);
      int gap;
      if (req_idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 14);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_cell_req      <= dots;
      req_first_of_word <= first;
      req_last_of_word  <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // Drop valid and wait until every predicted character has been seen.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Mostly well-formed words: optional capital sign, optional number sign
   // with digits, then random cells, flagged first and last. A few words
   // are left unterminated and some cells are pure noise.
   task automatic send_random_word();
      bit [5:0] cells [$];
      int       n;
      int       k;
      bit       tail_last;
      if ($urandom_range(0, 9) == 0) begin
         send_cell(6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
      end else begin
         if ($urandom_range(0, 3) == 0) cells.push_back(bgd_pkg::SIGN_CAPITAL);
         if ($urandom_range(0, 3) == 0) begin
            cells.push_back(bgd_pkg::SIGN_NUMBER);
            n = $urandom_range(1, 4);
            repeat (n) cells.push_back(DIGIT_DOTS[$urandom_range(0, 9)]);
         end
         if (cells.size() == 0 && $urandom_range(0, 2) == 0) n = 1;
         else n = $urandom_range(0, 5);
         if (cells.size() + n == 0) n = 1;
         repeat (n) begin
            if ($urandom_range(0, 2) == 0) cells.push_back(DIGIT_DOTS[$urandom_range(0, 9)]);
            else cells.push_back(6'($urandom_range(0, 63)));
         end
         tail_last = ($urandom_range(0, 19) != 0);
         for (k = 0; k < cells.size(); k++)
            send_cell(cells[k], k == 0, (k == cells.size() - 1) && tail_last);
      end
   endtask

   // Receiver: one long hold when asked, otherwise random stall bursts.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_due && !long_hold_taken) begin
            long_hold_taken = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (rsp_idle_on && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 14)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: abort when neither channel moves a word for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_cell_req      = '0;
      req_first_of_word = 1'b0;
      req_last_of_word  = 1'b0;
      req_idle_on       = 1'b1;
      items_sent        = 0;
      repeat (10) @(posedge clock);
      reset       <= 1'b0;
      rsp_idle_on <= 1'b1;

      // Directed cells.
      send_cell(6'h01, 1'b0, 1'b0);                 // mid-word with no word begun
      send_cell(6'h3F, 1'b1, 1'b1);                 // all dots: whole word "for"
      send_cell(6'h05, 1'b1, 1'b1);                 // longest whole word
      send_cell(6'h00, 1'b1, 1'b1);                 // empty cell: nothing
      send_cell(bgd_pkg::SIGN_CAPITAL, 1'b1, 1'b0); // capital ahead of a groupsign
      send_cell(6'h21, 1'b0, 1'b0);
      send_cell(6'h02, 1'b0, 1'b0);                 // lower groupsign inside a word
      send_cell(6'h14, 1'b0, 1'b1);
      send_cell(6'h02, 1'b1, 1'b0);                 // same cell at word start: comma
      send_cell(6'h2C, 1'b0, 1'b1);
      send_cell(bgd_pkg::SIGN_CAPITAL, 1'b1, 1'b0); // digits keep the capital armed
      send_cell(bgd_pkg::SIGN_NUMBER, 1'b0, 1'b0);
      send_cell(6'h01, 1'b0, 1'b0);
      send_cell(6'h1A, 1'b0, 1'b0);
      send_cell(6'h0D, 1'b0, 1'b1);                 // non-digit leaves number mode
      send_cell(6'h34, 1'b1, 1'b0);
      send_cell(6'h08, 1'b0, 1'b0);                 // unknown cell
      send_cell(6'h26, 1'b0, 1'b1);
      send_cell(bgd_pkg::SIGN_CAPITAL, 1'b1, 1'b1); // capital sign as a solo word
      send_cell(6'h01, 1'b0, 1'b1);
      send_cell(6'h0C, 1'b1, 1'b1);
      send_cell(6'h0C, 1'b0, 1'b0);
      send_cell(6'h3E, 1'b0, 1'b0);
      send_cell(6'h35, 1'b1, 1'b0);                 // whole-word cell not alone
      send_cell(6'h3A, 1'b0, 1'b1);

      // Hold the sender until the decoder has emptied.
      drain();

      // Back-pressure: receiver holds off while cells keep coming, so the
      // queue fills and the input stalls.
      req_idle_on   = 1'b0;
      rsp_idle_on   <= 1'b0;
      long_hold_due <= 1'b1;
      n_pressure_loop: begin
         int stop_at;
         stop_at = items_sent + PRESSURE_ITEMS;
         while (items_sent < stop_at) send_random_word();
      end
      drain();

      // Random words, with idling switched off now and then for a stretch.
      req_idle_on = 1'b1;
      rsp_idle_on <= 1'b1;
      n_random_loop: begin
         int stop_at;
         stop_at = items_sent + RANDOM_ITEMS;
         while (items_sent < stop_at) begin
            if ($urandom_range(0, 14) == 0) begin
               req_idle_on = !req_idle_on;
               rsp_idle_on <= req_idle_on;
            end
            send_random_word();
         end
      end

      // Tail with both sides at full rate.
      req_idle_on = 1'b0;
      rsp_idle_on <= 1'b0;
      n_calm_loop: begin
         int stop_at;
         stop_at = items_sent + CALM_ITEMS;
         while (items_sent < stop_at) send_random_word();
      end

      drain();
      repeat (12) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
